[rtl/dmct_pkg.sv]
// Shared types and constants of the Dirichlet-multinomial count table.
package dmct_pkg;

  localparam int CATEGORIES_DEF    = 1024;
  localparam int COUNT_BITS_DEF    = 24;
  localparam int LOG_FRAC_BITS_DEF = 16;

  localparam int CC_BITS   = 11;
  localparam int PE_BITS   = 32;
  localparam int PT_BITS   = 48;
  localparam int CFG_BITS  = 48;
  localparam int TOT_BITS  = 32;
  localparam int LOG_IN_W  = 64;
  localparam int LOG_OUT_W = 23;
  localparam int ICNT_W    = 24;
  localparam int ITEM_W    = 10;
  localparam int DELTA_W   = 16;
  localparam int PRIOR_SH  = 16;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [1:0] {
    CFG_CATEGORY_COUNT = 2'd0,
    CFG_PRIOR_EACH     = 2'd1,
    CFG_PRIOR_TOTAL    = 2'd2,
    CFG_NONE           = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    REQ_CHANGE = 2'd0,
    REQ_LOG    = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_DELTA  = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_READ, ST_UPD, ST_TOT, ST_WIPE,
    ST_ZCHK, ST_LOGN, ST_LOGD, ST_MUL, ST_SAT, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    LG_IDLE, LG_NORM, LG_LOAD, LG_SQ
  } log_state_t;

endpackage

[rtl/dmct_if.sv]
// Request and response channel interfaces.
interface dmct_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       req_type;
  logic [dmct_pkg::ITEM_W-1:0]      item;
  logic signed [dmct_pkg::DELTA_W-1:0] delta;
  modport source (output valid, req_type, item, delta, input ready);
  modport sink   (input valid, req_type, item, delta, output ready);
endinterface

interface dmct_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dmct_pkg::LOG_OUT_W-1:0] log_prob;
  logic [dmct_pkg::ICNT_W-1:0]           item_count;
  logic [dmct_pkg::TOT_BITS-1:0]         total_count;
  logic                                  impossible;
  logic                                  underflow;
  modport source (output valid, log_prob, item_count, total_count, impossible, underflow,
                  input ready);
  modport sink   (input valid, log_prob, item_count, total_count, impossible, underflow,
                  output ready);
endinterface

[rtl/dmct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dmct_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/dmct_log2.sv]
// Iterative fixed-point log2: normalising search then one squaring per cycle.
module dmct_log2 #(
  parameter int LOG_FRAC_BITS = dmct_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dmct_pkg::LOG_IN_W-1:0] x,
  output logic                          done,
  output logic [LOG_FRAC_BITS+7:0]      r
);
  localparam int GUARD = LOG_FRAC_BITS + 2;
  localparam int DW    = GUARD + 6;
  localparam int IW    = $clog2(GUARD + 1);

  dmct_pkg::log_state_t state, state_next;
  logic [63:0]   xn;
  logic [5:0]    s;
  logic [2:0]    k;
  logic [IW-1:0] i;
  logic [30:0]   m;
  logic [61:0]   sq;
  logic [31:0]   t;

  assign sq = 62'(m) * 62'(m);
  assign t  = sq[61:30];

  always_comb begin
    state_next = state;
    unique case (state)
      dmct_pkg::LG_IDLE: if (start) state_next = dmct_pkg::LG_NORM;
      dmct_pkg::LG_NORM: if (k == 3'd0) state_next = dmct_pkg::LG_LOAD;
      dmct_pkg::LG_LOAD: state_next = dmct_pkg::LG_SQ;
      dmct_pkg::LG_SQ:   if (i == IW'(1)) state_next = dmct_pkg::LG_IDLE;
      default:           state_next = dmct_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmct_pkg::LG_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == dmct_pkg::LG_SQ) && (i == IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dmct_pkg::LG_IDLE: begin
        xn <= x;
        s  <= 6'd0;
        k  <= 3'd5;
      end
      dmct_pkg::LG_NORM: begin
        // drop leading zero groups, widest first
        unique case (k)
          3'd5: if (xn[63:32] == '0) begin xn <= xn << 32; s <= s | 6'd32; end
          3'd4: if (xn[63:48] == '0) begin xn <= xn << 16; s <= s | 6'd16; end
          3'd3: if (xn[63:56] == '0) begin xn <= xn << 8;  s <= s | 6'd8;  end
          3'd2: if (xn[63:60] == '0) begin xn <= xn << 4;  s <= s | 6'd4;  end
          3'd1: if (xn[63:62] == '0) begin xn <= xn << 2;  s <= s | 6'd2;  end
          3'd0: if (!xn[63])         begin xn <= xn << 1;  s <= s | 6'd1;  end
          default: ;
        endcase
        k <= k - 3'd1;
      end
      dmct_pkg::LG_LOAD: begin
        m <= xn[63:33];
        r <= DW'(6'd63 - s);
        i <= IW'(GUARD);
      end
      dmct_pkg::LG_SQ: begin
        m <= t[31] ? t[31:1] : t[30:0];
        r <= {r[DW-2:0], t[31]};
        i <= i - IW'(1);
      end
      default: ;
    endcase
  end
endmodule

[rtl/dirichlet_multinomial_count_table_top.sv]
// Top level of the Dirichlet-multinomial count table.
// One request is taken at a time; ready is high only while the sequencer is idle.
// A change request steps through read, update, write back and total, and result.
// A log or delta log request runs the shared log2 unit twice, on the numerator and
// then on the denominator, besides the read, the multiply by ln2 and the rounding;
// trivial answers (one category, zero numerator, a delta request on a non-empty
// table) return without the log2 runs. A clear walks the count RAM one entry a
// cycle. After reset the same walk runs once before the first request is taken;
// configuration writes are taken at all times. A finished result sits in an output
// register so the next request may be accepted while it waits.
module dirichlet_multinomial_count_table_top #(
  parameter int CATEGORIES    = dmct_pkg::CATEGORIES_DEF,
  parameter int COUNT_BITS    = dmct_pkg::COUNT_BITS_DEF,
  parameter int LOG_FRAC_BITS = dmct_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  dmct_req_if.sink                      req,
  dmct_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dmct_pkg::CFG_BITS-1:0] cfg_data
);
  localparam int AW    = $clog2(CATEGORIES);
  localparam int NCB   = $clog2(CATEGORIES + 1);
  localparam int NCW   = (NCB > dmct_pkg::CC_BITS) ? NCB : dmct_pkg::CC_BITS;
  localparam int GUARD = LOG_FRAC_BITS + 2;
  localparam int DW    = GUARD + 6;
  localparam int PW    = DW + 30;
  localparam int MW    = DW - 1;
  localparam int SW    = COUNT_BITS + 2;
  localparam int TW    = dmct_pkg::TOT_BITS + 2;
  localparam int LW    = dmct_pkg::LOG_IN_W;
  localparam int OW    = dmct_pkg::LOG_OUT_W;
  localparam logic [MW-1:0]         LOG_SAT   = MW'(64) << LOG_FRAC_BITS;
  localparam logic [OW-1:0]         LOG_SAT_F = OW'(0) - OW'(LOG_SAT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  dmct_pkg::state_t state, state_next;

  // configuration
  logic [dmct_pkg::CC_BITS-1:0] cat_cnt;
  logic [dmct_pkg::PE_BITS-1:0] prior_each;
  logic [dmct_pkg::PT_BITS-1:0] prior_total;

  // request held over its whole run
  logic [1:0]                     rtype;
  logic [AW-1:0]                  addr;
  logic signed [dmct_pkg::DELTA_W-1:0] dlt;
  logic                           valid_item;
  logic [NCW-1:0]                 ncat;
  logic [COUNT_BITS-1:0]          cur;
  logic [dmct_pkg::TOT_BITS-1:0]  total;
  logic [LW-1:0]                  num, den;
  logic signed [SW-1:0]           applied;
  logic                           uf, imp;
  logic [OW-1:0]                  log_val;
  logic [AW-1:0]                  wipe;
  logic [DW-1:0]                  ln, diff;
  logic [PW-1:0]                  prod;

  // RAM
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  logic [AW-1:0]         ram_raddr;

  // log2 unit
  logic          lg_start, lg_done;
  logic [LW-1:0] lg_x;
  logic [DW-1:0] lg_r;

  // change arithmetic
  logic [COUNT_BITS-1:0]  rd_cur;
  logic signed [SW-1:0]   nv_s;
  logic signed [TW-1:0]   tot_s;
  logic [PW:0]            rnd;
  logic [MW-1:0]          mag;
  logic                   wipe_last;

  dmct_ram #(.WIDTH(COUNT_BITS), .DEPTH(CATEGORIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  dmct_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log2 (
    .clk  (clk),
    .rst  (rst),
    .start(lg_start),
    .x    (lg_x),
    .done (lg_done),
    .r    (lg_r)
  );

  assign ncat = (cat_cnt == '0) ? NCW'(1) :
                (NCW'(cat_cnt) > NCW'(CATEGORIES)) ? NCW'(CATEGORIES) : NCW'(cat_cnt);
  assign req.ready = (state == dmct_pkg::ST_IDLE);
  assign wipe_last = (wipe == AW'(CATEGORIES - 1));
  assign rd_cur    = valid_item ? ram_rdata : '0;
  assign nv_s      = SW'($signed({2'b00, cur})) + SW'(dlt);
  assign tot_s     = TW'($signed({2'b00, total})) + TW'(applied);
  assign rnd       = (PW + 1)'(prod) + ((PW + 1)'(1) << 31);
  assign mag       = rnd[PW:32];

  // read at the request's item while idle, write on the walks and the write-back
  assign ram_raddr = AW'(req.item);
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wipe;
    ram_wdata = '0;
    unique case (state)
      dmct_pkg::ST_INIT, dmct_pkg::ST_WIPE: ram_we = 1'b1;
      dmct_pkg::ST_TOT: begin
        ram_we    = valid_item;
        ram_waddr = addr;
        ram_wdata = COUNT_BITS'($unsigned(SW'(cur) + applied));
      end
      default: ;
    endcase
  end

  // start the log unit on the numerator, then on the denominator
  always_comb begin
    lg_start = 1'b0;
    lg_x     = num;
    if (state == dmct_pkg::ST_ZCHK && num != '0 && den != '0) begin
      lg_start = 1'b1;
    end else if (state == dmct_pkg::ST_LOGN && lg_done) begin
      lg_start = 1'b1;
      lg_x     = den;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dmct_pkg::ST_INIT: if (wipe_last) state_next = dmct_pkg::ST_IDLE;
      dmct_pkg::ST_IDLE: if (req.valid) state_next = dmct_pkg::ST_READ;
      dmct_pkg::ST_READ: begin
        unique case (rtype)
          dmct_pkg::REQ_CHANGE: state_next = dmct_pkg::ST_UPD;
          dmct_pkg::REQ_LOG:
            state_next = (cat_cnt > dmct_pkg::CC_BITS'(1)) ? dmct_pkg::ST_ZCHK
                                                            : dmct_pkg::ST_DONE;
          dmct_pkg::REQ_CLEAR:  state_next = dmct_pkg::ST_WIPE;
          default:
            state_next = (total == '0) ? dmct_pkg::ST_ZCHK : dmct_pkg::ST_DONE;
        endcase
      end
      dmct_pkg::ST_UPD:  state_next = dmct_pkg::ST_TOT;
      dmct_pkg::ST_TOT:  state_next = dmct_pkg::ST_DONE;
      dmct_pkg::ST_WIPE: if (wipe_last) state_next = dmct_pkg::ST_DONE;
      dmct_pkg::ST_ZCHK: state_next = lg_start ? dmct_pkg::ST_LOGN : dmct_pkg::ST_DONE;
      dmct_pkg::ST_LOGN: if (lg_done) state_next = dmct_pkg::ST_LOGD;
      dmct_pkg::ST_LOGD:
        if (lg_done) state_next = (ln >= lg_r) ? dmct_pkg::ST_DONE : dmct_pkg::ST_MUL;
      dmct_pkg::ST_MUL:  state_next = dmct_pkg::ST_SAT;
      dmct_pkg::ST_SAT:  state_next = dmct_pkg::ST_DONE;
      dmct_pkg::ST_DONE: if (!rsp.valid || rsp.ready) state_next = dmct_pkg::ST_IDLE;
      default:           state_next = dmct_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dmct_pkg::ST_INIT;
      wipe        <= '0;
      total       <= '0;
      cat_cnt     <= dmct_pkg::CC_BITS'(1);
      prior_each  <= dmct_pkg::PE_BITS'(65536);
      prior_total <= dmct_pkg::PT_BITS'(65536);
      rsp.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (dmct_pkg::cfg_index_t'(cfg_index))
          dmct_pkg::CFG_CATEGORY_COUNT: cat_cnt     <= cfg_data[dmct_pkg::CC_BITS-1:0];
          dmct_pkg::CFG_PRIOR_EACH:     prior_each  <= cfg_data[dmct_pkg::PE_BITS-1:0];
          dmct_pkg::CFG_PRIOR_TOTAL:    prior_total <= cfg_data[dmct_pkg::PT_BITS-1:0];
          default: ;
        endcase
      end
      if (state == dmct_pkg::ST_INIT || state == dmct_pkg::ST_WIPE) begin
        wipe <= wipe_last ? '0 : wipe + AW'(1);
      end
      if (state == dmct_pkg::ST_WIPE) begin
        total <= '0;
      end
      // total: clamp at zero with a flag, saturate at the top without one
      if (state == dmct_pkg::ST_TOT && valid_item) begin
        if (tot_s < 0) begin
          total <= '0;
        end else if (tot_s > TW'({2'b00, {dmct_pkg::TOT_BITS{1'b1}}})) begin
          total <= '1;
        end else begin
          total <= tot_s[dmct_pkg::TOT_BITS-1:0];
        end
      end
      // load a finished result, hold one that waits, drop one that is taken
      rsp.valid <= (state == dmct_pkg::ST_DONE && (!rsp.valid || rsp.ready)) ||
                   (rsp.valid && !rsp.ready);
    end
  end

  // request payload and datapath
  always_ff @(posedge clk) begin
    unique case (state)
      dmct_pkg::ST_IDLE: begin
        rtype      <= req.req_type;
        addr       <= AW'(req.item);
        dlt        <= req.delta;
        valid_item <= NCW'(req.item) < ncat;
        uf         <= 1'b0;
        imp        <= 1'b0;
        log_val    <= '0;
      end
      dmct_pkg::ST_READ: begin
        cur <= rd_cur;
        if (rtype == dmct_pkg::REQ_DELTA) begin
          num <= LW'(1);
          den <= LW'(ncat);
          if (total != '0 && dmct_pkg::TOT_BITS'(rd_cur) != total) begin
            imp     <= 1'b1;
            log_val <= LOG_SAT_F;
          end
        end else begin
          num <= (LW'(rd_cur) << dmct_pkg::PRIOR_SH) + LW'(prior_each);
          den <= (LW'(total) << dmct_pkg::PRIOR_SH) + LW'(prior_total);
        end
      end
      dmct_pkg::ST_UPD: begin
        // amount actually applied after the count's own clamp
        if (nv_s < 0) begin
          applied <= -SW'($signed({2'b00, cur}));
          uf      <= valid_item;
        end else if (nv_s > SW'({2'b00, COUNT_MAX})) begin
          applied <= SW'({2'b00, COUNT_MAX}) - SW'({2'b00, cur});
        end else begin
          applied <= SW'(dlt);
        end
      end
      dmct_pkg::ST_TOT: begin
        if (valid_item) begin
          cur <= COUNT_BITS'($unsigned(SW'(cur) + applied));
          if (tot_s < 0) uf <= 1'b1;
        end
      end
      dmct_pkg::ST_WIPE: cur <= '0;
      dmct_pkg::ST_ZCHK: if (num == '0) log_val <= LOG_SAT_F;
      dmct_pkg::ST_LOGN: if (lg_done) ln <= lg_r;
      dmct_pkg::ST_LOGD: diff <= lg_r - ln;
      dmct_pkg::ST_MUL:  prod <= PW'(diff) * PW'(dmct_pkg::LN2_Q30);
      dmct_pkg::ST_SAT:  log_val <= OW'(0) - OW'((mag > LOG_SAT) ? LOG_SAT : mag);
      default: ;
    endcase
    if (state == dmct_pkg::ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.log_prob    <= log_val;
      rsp.item_count  <= dmct_pkg::ICNT_W'(cur);
      rsp.total_count <= total;
      rsp.impossible  <= imp;
      rsp.underflow   <= uf;
    end
  end
endmodule
